FILE: hw/rtl/whp_pkg.sv
`default_nettype none

package whp_pkg;

    // Tags as they appear in the little-endian shift of the last four bytes
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FIELD_BASE = 32'd20;
    localparam logic [31:0] FIELD_LAST = 32'd35;
    localparam logic [31:0] CHUNK_HDR  = 32'd8;

    localparam logic [31:0] OFF_RIFF_END = 32'd3;
    localparam logic [31:0] OFF_WAVE_END = 32'd11;
    localparam logic [31:0] OFF_FMT_END  = 32'd15;
    localparam logic [31:0] OFF_SIZE_END = 32'd19;
    localparam logic [31:0] REL_TAG_END  = 32'd3;
    localparam logic [31:0] REL_SIZE_END = 32'd7;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NO_RIFF = 3'd1;
    localparam logic [2:0] ERR_NO_WAVE = 3'd2;
    localparam logic [2:0] ERR_NO_FMT  = 3'd3;
    localparam logic [2:0] ERR_NO_DATA = 3'd4;

    typedef enum logic [5:0] {
        PH_HEAD    = 6'b000001,
        PH_SEARCH  = 6'b000010,
        PH_DSIZE   = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_DRAIN   = 6'b010000,
        PH_FAULT   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  error_code;
        logic [15:0] audio_format;
        logic [15:0] num_channels;
        logic [31:0] sampling_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/whp_core.sv
`default_nettype none

module whp_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             beat_fire,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output whp_pkg::result_t      res,
    output logic                  res_valid
);
    import whp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] remain_reg, remain_next;

    logic [31:0] rel;
    logic        past_chunk;
    logic [5:0]  field_rel;
    logic [3:0]  field_idx;
    logic        in_field;
    logic [33:0] chunk_sum;
    logic [31:0] remain_dec;
    logic [2:0]  early_code;

    assign rel        = offset_reg - chunk_reg;
    assign past_chunk = offset_reg >= chunk_reg;
    assign field_rel  = offset_reg[5:0] - FIELD_BASE[5:0];
    assign field_idx  = field_rel[3:0];
    assign in_field   = (offset_reg >= FIELD_BASE) && (offset_reg <= FIELD_LAST);
    assign remain_dec = remain_reg - 32'd1;

    // tag_next already holds this byte; the next chunk start saturates
    assign chunk_sum = {2'b00, chunk_reg} + {2'b00, CHUNK_HDR} + {2'b00, tag_next};

    always_comb
    begin
        if (offset_reg <= 32'd2)
            early_code = ERR_NO_RIFF;
        else if (offset_reg <= 32'd10)
            early_code = ERR_NO_WAVE;
        else if (offset_reg <= 32'd14)
            early_code = ERR_NO_FMT;
        else
            early_code = ERR_NO_DATA;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        chunk_next    = chunk_reg;
        format_next   = format_reg;
        channels_next = channels_reg;
        rate_next     = rate_reg;
        brate_next    = brate_reg;
        align_next    = align_reg;
        bits_next     = bits_reg;
        remain_next   = remain_reg;
        res           = '0;
        res_valid     = 1'b0;

        if (phase_reg == PH_HEAD || phase_reg == PH_SEARCH || phase_reg == PH_DSIZE)
            tag_next = {data_byte, tag_reg[31:8]};
        else
            tag_next = tag_reg;

        // format fields are captured while walking chunks
        if ((phase_reg == PH_SEARCH || phase_reg == PH_DSIZE) && in_field)
        begin
            case (field_idx) inside
                [4'd0:4'd1]:   format_next   = format_reg
                                               | ({8'h00, data_byte} << {field_idx[0], 3'b000});
                [4'd2:4'd3]:   channels_next = channels_reg
                                               | ({8'h00, data_byte} << {field_idx[0], 3'b000});
                [4'd4:4'd7]:   rate_next     = rate_reg
                                               | ({24'h0, data_byte} << {field_idx[1:0], 3'b000});
                [4'd8:4'd11]:  brate_next    = brate_reg
                                               | ({24'h0, data_byte} << {field_idx[1:0], 3'b000});
                [4'd12:4'd13]: align_next    = align_reg
                                               | ({8'h00, data_byte} << {field_idx[0], 3'b000});
                default:       bits_next     = bits_reg
                                               | ({8'h00, data_byte} << {field_idx[0], 3'b000});
            endcase
        end

        case (phase_reg)
            PH_HEAD:
            begin
                if (offset_reg == OFF_RIFF_END && tag_next != TAG_RIFF)
                begin
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_NO_RIFF;
                    res_valid       = 1'b1;
                    phase_next      = PH_FAULT;
                end
                else if (offset_reg == OFF_WAVE_END && tag_next != TAG_WAVE)
                begin
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_NO_WAVE;
                    res_valid       = 1'b1;
                    phase_next      = PH_FAULT;
                end
                else if (offset_reg == OFF_FMT_END && tag_next != TAG_FMT)
                begin
                    res.result_kind = KIND_ERROR;
                    res.error_code  = ERR_NO_FMT;
                    res_valid       = 1'b1;
                    phase_next      = PH_FAULT;
                end
                else if (offset_reg == OFF_SIZE_END)
                begin
                    chunk_next = (33'(tag_next) + 33'(FIELD_BASE) > 33'h0_FFFF_FFFF)
                               ? 32'hFFFF_FFFF : tag_next + FIELD_BASE;
                    phase_next = PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                if (past_chunk)
                begin
                    if (rel == REL_TAG_END && tag_next == TAG_DATA)
                        phase_next = PH_DSIZE;
                    else if (rel == REL_SIZE_END)
                        chunk_next = (chunk_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF
                                                                 : chunk_sum[31:0];
                end
            end
            PH_DSIZE:
            begin
                if (past_chunk && rel == REL_SIZE_END)
                begin
                    res.result_kind     = KIND_HEADER;
                    res.audio_format    = format_next;
                    res.num_channels    = channels_next;
                    res.sampling_rate   = rate_next;
                    res.byte_rate       = brate_next;
                    res.block_align     = align_next;
                    res.bits_per_sample = bits_next;
                    res.data_size       = tag_next;
                    res_valid           = 1'b1;
                    remain_next         = tag_next;
                    phase_next          = (tag_next != 32'd0) ? PH_PAYLOAD : PH_DRAIN;
                end
            end
            PH_PAYLOAD:
            begin
                res.result_kind  = KIND_PAYLOAD;
                res.payload_byte = data_byte;
                res.last_payload = (remain_dec == 32'd0);
                res_valid        = 1'b1;
                remain_next      = remain_dec;
                if (remain_dec == 32'd0)
                    phase_next = PH_DRAIN;
            end
            default:
            begin
            end
        endcase

        offset_next = (offset_reg == 32'hFFFF_FFFF) ? offset_reg : offset_reg + 32'd1;

        // end of file: report anything unfinished, then start over
        if (last_byte)
        begin
            if (phase_next != PH_DRAIN && phase_next != PH_FAULT)
            begin
                res             = '0;
                res.result_kind = KIND_ERROR;
                res.error_code  = (phase_next != PH_HEAD) ? ERR_NO_DATA : early_code;
                res_valid       = 1'b1;
            end
            phase_next    = PH_HEAD;
            offset_next   = '0;
            tag_next      = '0;
            chunk_next    = '0;
            format_next   = '0;
            channels_next = '0;
            rate_next     = '0;
            brate_next    = '0;
            align_next    = '0;
            bits_next     = '0;
            remain_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD;
            offset_reg   <= '0;
            tag_reg      <= '0;
            chunk_reg    <= '0;
            format_reg   <= '0;
            channels_reg <= '0;
            rate_reg     <= '0;
            brate_reg    <= '0;
            align_reg    <= '0;
            bits_reg     <= '0;
            remain_reg   <= '0;
        end
        else if (beat_fire)
        begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            tag_reg      <= tag_next;
            chunk_reg    <= chunk_next;
            format_reg   <= format_next;
            channels_reg <= channels_next;
            rate_reg     <= rate_next;
            brate_reg    <= brate_next;
            align_reg    <= align_next;
            bits_reg     <= bits_next;
            remain_reg   <= remain_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wav_header_parser.sv
`default_nettype none

// Channel  Handshake              Beat fields
// ------   ---------------------  -----------------------------------------------
// in       in_valid / in_ready    data_byte, last_byte
// out      out_valid / out_ready  result_kind, error_code, header fields,
//                                 data_size, payload_byte, last_payload
//
// One input beat per cycle while in_ready is high; any result reaches out next cycle.
// in_ready is low only while a result is held and out_ready is low.
// Parser state advances only on an accepted input beat; last_byte returns it to
// the reset state. Reset clears the parser and empties the output register.

module wav_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [2:0]       error_code,
    output logic [15:0]      audio_format,
    output logic [15:0]      num_channels,
    output logic [31:0]      sampling_rate,
    output logic [31:0]      byte_rate,
    output logic [15:0]      block_align,
    output logic [15:0]      bits_per_sample,
    output logic [31:0]      data_size,
    output logic [7:0]       payload_byte,
    output logic             last_payload
);
    import whp_pkg::*;

    result_t res;
    logic    res_valid;
    logic    beat_fire;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign beat_fire = in_valid && in_ready;

    whp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_fire (beat_fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res       (res),
        .res_valid (res_valid)
    );

    always_comb
    begin
        if (beat_fire)
            out_valid_next = res_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (beat_fire && res_valid)
            out_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_reg.result_kind;
    assign error_code      = out_reg.error_code;
    assign audio_format    = out_reg.audio_format;
    assign num_channels    = out_reg.num_channels;
    assign sampling_rate   = out_reg.sampling_rate;
    assign byte_rate       = out_reg.byte_rate;
    assign block_align     = out_reg.block_align;
    assign bits_per_sample = out_reg.bits_per_sample;
    assign data_size       = out_reg.data_size;
    assign payload_byte    = out_reg.payload_byte;
    assign last_payload    = out_reg.last_payload;

endmodule

`default_nettype wire
